// File: hdl/pdec_pkg.sv
// Shared types, constants and hex helpers for the percent decoder.
// Used by every module in hdl/; depends on nothing else.
package pdec_pkg;

   localparam logic [7:0] PCT_CHAR = 8'h25;
   localparam int unsigned MAX_OUT = 3;

   // Escape phase, one-hot.
   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_PCT  = 3'b010,
      PH_DIG  = 3'b100
   } pdec_phase_type;

   // All result bytes caused by one accepted item.
   typedef struct packed {
      logic [MAX_OUT-1:0][7:0] data;
      logic [1:0]              count;
      logic                    eot;
   } pdec_bundle_type;

   // One queue slot as seen by the writer or the reader.
   typedef struct packed {
      logic            valid;
      pdec_bundle_type bundle;
   } pdec_slot_type;

   function automatic logic is_hex(input logic [7:0] c);
      logic dig;
      logic upper;
      logic lower;
      dig   = (c >= 8'h30) && (c <= 8'h39);
      upper = (c >= 8'h41) && (c <= 8'h46);
      lower = (c >= 8'h61) && (c <= 8'h66);
      return dig || upper || lower;
   endfunction

   // Valid only for hex digits: letters have low nibble 1..6 -> 10..15.
   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [3:0] v;
      if (c[6]) begin
         v = c[3:0] + 4'd9;
      end else begin
         v = c[3:0];
      end
      return v;
   endfunction

endpackage

// File: hdl/pdec_front.sv
// Front end of the percent decoder: holds the escape phase and held digit,
// classifies each accepted byte and writes any result bundle to the queue.
// Depends on pdec_pkg.
module pdec_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             in_byte,
   input  logic                   end_of_text,
   output pdec_pkg::pdec_slot_type wr
);
   import pdec_pkg::*;

   pdec_phase_type  phase_ff, phase_in;
   logic [7:0]      held_ff, held_in;
   pdec_bundle_type bun;
   logic [1:0]      n;
   logic            rescan;

   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      bun      = '0;
      n        = '0;
      rescan   = 1'b0;

      unique case (phase_ff)
         PH_PCT: begin
            if (is_hex(in_byte)) begin
               phase_in = PH_DIG;
               held_in  = in_byte;
            end else begin
               bun.data[n] = PCT_CHAR;
               n           = n + 2'd1;
               rescan      = 1'b1;
            end
         end
         PH_DIG: begin
            if (is_hex(in_byte)) begin
               bun.data[n] = {hex_val(held_ff), hex_val(in_byte)};
               n           = n + 2'd1;
               phase_in    = PH_IDLE;
               held_in     = '0;
            end else begin
               bun.data[n] = PCT_CHAR;
               n           = n + 2'd1;
               bun.data[n] = held_ff;
               n           = n + 2'd1;
               held_in     = '0;
               rescan      = 1'b1;
            end
         end
         default: begin
            rescan = 1'b1;
         end
      endcase

      // Scan the byte afresh: it may open a new escape.
      if (rescan) begin
         if (in_byte == PCT_CHAR) begin
            phase_in = PH_PCT;
            held_in  = '0;
         end else begin
            bun.data[n] = in_byte;
            n           = n + 2'd1;
            phase_in    = PH_IDLE;
         end
      end

      // Flush a pending escape at end of text.
      if (end_of_text) begin
         if (phase_in == PH_PCT) begin
            bun.data[n] = PCT_CHAR;
            n           = n + 2'd1;
         end else if (phase_in == PH_DIG) begin
            bun.data[n] = PCT_CHAR;
            n           = n + 2'd1;
            bun.data[n] = held_in;
            n           = n + 2'd1;
         end
         phase_in = PH_IDLE;
         held_in  = '0;
      end

      bun.count = n;
      bun.eot   = end_of_text;
   end

   assign wr.valid  = accept && (n != 2'd0);
   assign wr.bundle = bun;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         held_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   a_eot_has_result: assert property (@(posedge clock) disable iff (reset)
      accept && end_of_text |-> wr.valid)
      else $error("end of text produced no result");

   a_eot_clears: assert property (@(posedge clock) disable iff (reset)
      accept && end_of_text |=> phase_ff == PH_IDLE && held_ff == 8'h00)
      else $error("escape state not cleared after end of text");

endmodule

// File: hdl/pdec_fifo.sv
// Short queue of result bundles between the front and back ends.
// Depends on pdec_pkg.
module pdec_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pdec_pkg::pdec_slot_type wr,
   output logic                    full,
   output pdec_pkg::pdec_slot_type head,
   input  logic                    rd_pop
);
   import pdec_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

   pdec_bundle_type mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            do_wr;
   logic            do_rd;

   assign full        = (cnt_ff == DEPTH_CNT);
   assign head.valid  = (cnt_ff != '0);
   assign head.bundle = mem_ff[rd_ptr_ff];

   assign do_wr = wr.valid && !full;
   assign do_rd = rd_pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (!do_wr && do_rd) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr.bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   a_no_write_when_full: assert property (@(posedge clock) disable iff (reset)
      !(wr.valid && full))
      else $error("bundle written into full queue");

endmodule

// File: hdl/pdec_back.sv
// Back end of the percent decoder: unpacks the head bundle one byte per
// transfer into the result register. Depends on pdec_pkg.
module pdec_back (
   input  logic                    clock,
   input  logic                    reset,
   input  pdec_pkg::pdec_slot_type head,
   output logic                    rd_pop,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_run_end,
   output logic                    rsp_text_end
);
   import pdec_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic [1:0] idx_ff, idx_in;
   logic [7:0] byte_ff;
   logic       run_ff;
   logic       text_ff;
   logic       pop_acc;
   logic       load;
   logic       last;

   assign pop_acc = rsp_pop && out_valid_ff;
   assign load    = head.valid && (!out_valid_ff || pop_acc);
   assign last    = (idx_ff == head.bundle.count - 2'd1);
   assign rd_pop  = load && last;

   always_comb begin
      out_valid_in = out_valid_ff;
      idx_in       = idx_ff;
      if (load) begin
         out_valid_in = 1'b1;
         idx_in       = last ? 2'd0 : idx_ff + 2'd1;
      end else if (pop_acc) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= head.bundle.data[idx_ff];
         run_ff  <= last;
         text_ff <= last && head.bundle.eot;
      end
   end

   assign rsp_empty    = !out_valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_run_end  = run_ff;
   assign rsp_text_end = text_ff;

   a_idx_in_bundle: assert property (@(posedge clock) disable iff (reset)
      head.valid |-> idx_ff < head.bundle.count)
      else $error("byte index beyond bundle");

   a_idle_idx_zero: assert property (@(posedge clock) disable iff (reset)
      !head.valid |-> idx_ff == 2'd0)
      else $error("byte index left over with no bundle");

   a_text_end_is_run_end: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && text_ff |-> run_ff)
      else $error("text end without run end");

endmodule

// File: hdl/percent_decoder.sv
// Percent decoder for URL-encoded text: top level.
// Instantiates pdec_front, pdec_fifo and pdec_back; depends on pdec_pkg.
//
// Input channel: one raw byte per transfer on req_in_byte, with
// req_end_of_text high on the last byte of a text. A byte is taken at a
// rising edge with req_push high and req_full low.
// Result channel: decoded bytes, oldest first, are on rsp_out_byte while
// rsp_empty is low and leave at an edge with rsp_pop high. rsp_run_end
// marks the last byte caused by one input byte, rsp_text_end the last byte
// of a text. One input byte causes zero to three result bytes.
// A byte's first result goes via a queue slot, then the result register.
// Throughput: one input byte per cycle while req_full is low, one result
// byte per cycle while rsp_pop is held high; the result side sets the
// sustained rate when bytes expand.
// A QUEUE_DEPTH-entry bundle queue parts the front end from the result
// register, so a stalled receiver backs up into req_full only once the
// queue fills; nothing is dropped.
// Reset (synchronous) clears the escape phase, empties the queue and the
// result register.
module percent_decoder #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_text,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_end,
   output logic       rsp_text_end
);
   import pdec_pkg::*;

   pdec_slot_type wr;
   pdec_slot_type head;
   logic          accept;
   logic          rd_pop;

   assign accept = req_push && !req_full;

   pdec_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_in_byte),
      .end_of_text (req_end_of_text),
      .wr          (wr)
   );

   pdec_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock  (clock),
      .reset  (reset),
      .wr     (wr),
      .full   (req_full),
      .head   (head),
      .rd_pop (rd_pop)
   );

   pdec_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .rd_pop       (rd_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_end  (rsp_run_end),
      .rsp_text_end (rsp_text_end)
   );

endmodule
